// ----- rtl/fpsr_pkg.sv -----
// Package for the flow packet sequence recorder.
// Types, command/status codes, register indexes and constants.
// No dependencies.
package fpsr_pkg;

  // Command codes
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_RECORDED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_ZERO_SKIP = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;

  // Configuration register indexes (selected by paddr[2])
  localparam logic REG_INCLUDE_ZERO = 1'b0;
  localparam logic REG_SKIP_DUP     = 1'b1;

  localparam int APB_AW = 3;

  // A drop of more than this below the remembered value counts as a wrap
  localparam logic [31:0] WRAP_LIMIT = 32'd4252017623;

  // Direction index: client-to-server entries live at 0
  localparam logic DIR_CLIENT = 1'b0;
  localparam logic DIR_SERVER = 1'b1;

  typedef struct packed {
    logic include_zero_length;
    logic skip_duplicates;
  } cfg_t;

  // Per-direction memory of the last packet not skipped as a duplicate
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] length;
    logic [7:0]  flags;
  } hist_t;

  // One recorded packet
  typedef struct packed {
    logic [63:0] arrival;
    logic        direction;
    logic [7:0]  flags;
    logic [15:0] size;
  } entry_t;

endpackage

// ----- rtl/fpsr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fpsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fpsr_apb.sv -----
// APB configuration registers of the packet sequence recorder.
// Depends on fpsr_pkg.
module fpsr_apb
  import fpsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_INCLUDE_ZERO: cfg.include_zero_length <= pwdata[0];
        REG_SKIP_DUP:     cfg.skip_duplicates     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_INCLUDE_ZERO: prdata[0] = cfg.include_zero_length;
      REG_SKIP_DUP:     prdata[0] = cfg.skip_duplicates;
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/fpsr_dup.sv -----
// Retransmission match: compares a packet against its direction's history.
// Depends on fpsr_pkg.
module fpsr_dup
  import fpsr_pkg::*;
(
  input  hist_t cur,
  input  hist_t prev,
  output logic  match
);

  logic [31:0] seq_diff;
  logic [31:0] ack_diff;
  logic        seq_stale;
  logic        ack_stale;

  // wrap-aware "did not advance": at most prev, and not far enough below to be a wrap
  assign seq_diff  = prev.seq - cur.seq;
  assign ack_diff  = prev.ack - cur.ack;
  assign seq_stale = (cur.seq <= prev.seq) && (seq_diff <= WRAP_LIMIT);
  assign ack_stale = (cur.ack <= prev.ack) && (ack_diff <= WRAP_LIMIT);

  assign match = seq_stale && ack_stale &&
                 (cur.length == prev.length) && (cur.flags == prev.flags);

endmodule

// ----- rtl/flow_packet_sequence_recorder_top.sv -----
// Flow packet sequence recorder, top level.
// Depends on fpsr_pkg, fpsr_ram, fpsr_apb, fpsr_dup.
//
// Usage:
//   Input words are issued with start and taken at an edge where busy is low.
//   command selects packet processing or a read of a recorded entry; new_flow
//   clears the record (count and per-direction history) before the word runs.
//   Each word yields one result word, shown on the result ports for one cycle
//   while done is high. The receiver cannot stall; results are never held.
//   A taken word sets busy, and no new word is taken while busy is high. On
//   acceptance the history RAM and the entry RAM are read (registered read
//   data); in the busy cycle the block decides, writes the RAMs as the
//   outcome needs, registers the result word and raises done.
//   Configuration goes through the APB port (include_zero_length at 0x0,
//   skip_duplicates at 0x4) and must be written by the user only while the
//   block is idle; the block itself does not enforce this.
//   Reset clears the configuration, the count and the history valid bits;
//   no clearing pass is needed, entries above the count are never shown.
module flow_packet_sequence_recorder_top
  import fpsr_pkg::*;
#(
  parameter int MAX_PACKETS = 32
) (
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic              command,
  input  logic              new_flow,
  input  logic              from_client,
  input  logic              is_tcp,
  input  logic [31:0]       seq_number,
  input  logic [31:0]       ack_number,
  input  logic [15:0]       payload_length,
  input  logic [15:0]       wire_length,
  input  logic [7:0]        tcp_flag_bits,
  input  logic [63:0]       arrival_time,
  input  logic [4:0]        read_index,
  // result channel
  output logic              done,
  output logic [2:0]        status,
  output logic [5:0]        recorded_count,
  output logic              want_more,
  output logic [15:0]       entry_size,
  output logic [7:0]        entry_flags,
  output logic              entry_direction,
  output logic [63:0]       entry_time
);

  localparam int CW = $clog2(MAX_PACKETS + 1);
  localparam int AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PACKETS);

  cfg_t cfg;

  fpsr_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------
  // Accept and capture the input word
  // ---------------------------------------------------------------
  logic accept;
  logic dir_in;

  assign accept = start && !busy;
  assign dir_in = from_client ? DIR_CLIENT : DIR_SERVER;

  logic        cmd_q;
  logic        nf_q;
  logic        fc_q;
  logic        dir_q;
  logic        tcp_q;
  hist_t       cur_q;
  logic [15:0] wlen_q;
  logic [63:0] ts_q;
  logic [4:0]  ridx_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q         <= command;
      nf_q          <= new_flow;
      fc_q          <= from_client;
      dir_q         <= dir_in;
      tcp_q         <= is_tcp;
      cur_q.seq     <= seq_number;
      cur_q.ack     <= ack_number;
      cur_q.length  <= payload_length;
      cur_q.flags   <= tcp_flag_bits;
      wlen_q        <= wire_length;
      ts_q          <= arrival_time;
      ridx_q        <= read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= accept;
    end
  end

  // ---------------------------------------------------------------
  // Memories: per-direction history and recorded entries
  // ---------------------------------------------------------------
  logic              hist_we;
  hist_t             hist_rd;
  logic              ent_we;
  entry_t            ent_wdata;
  entry_t            ent_rd;
  logic [AW-1:0]     ent_waddr;
  logic [AW-1:0]     ent_raddr;
  logic [AW+4:0]     ridx_ext;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_eff;
  logic [CW-1:0]     cnt_next;

  // read address from the input port; only meaningful when ridx is below the count
  assign ridx_ext  = {{AW{1'b0}}, read_index};
  assign ent_raddr = ridx_ext[AW-1:0];

  fpsr_ram #(
    .WIDTH ($bits(hist_t)),
    .DEPTH (2)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (dir_q),
    .wdata (cur_q),
    .raddr (dir_in),
    .rdata (hist_rd)
  );

  fpsr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PACKETS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  // ---------------------------------------------------------------
  // Decide: runs in the busy cycle
  // ---------------------------------------------------------------
  logic [1:0]      hist_valid;
  logic [1:0]      hist_valid_next;
  logic            hv;
  hist_t           hist_eff;
  logic            dup_match;
  logic            is_dup;
  logic            ridx_ok;
  logic [2:0]      st_next;
  entry_t          out_ent_next;
  logic [CW+4:0]   ridx_cmp;
  logic [CW+4:0]   cnt_cmp;

  assign cnt_eff  = nf_q ? '0 : cnt;
  assign hv       = !nf_q && hist_valid[dir_q];
  assign hist_eff = hv ? hist_rd : '0;

  fpsr_dup u_dup (
    .cur   (cur_q),
    .prev  (hist_eff),
    .match (dup_match)
  );

  assign is_dup    = cfg.skip_duplicates && tcp_q && (cnt_eff != '0) && dup_match;
  assign ridx_cmp  = {{CW{1'b0}}, ridx_q};
  assign cnt_cmp   = {5'b0, cnt_eff};
  assign ridx_ok   = ridx_cmp < cnt_cmp;
  assign ent_waddr = cnt_eff[AW-1:0];

  assign ent_wdata.arrival   = ts_q;
  assign ent_wdata.direction = fc_q;
  assign ent_wdata.flags     = cur_q.flags;
  assign ent_wdata.size      = wlen_q;

  always_comb begin
    hist_we      = 1'b0;
    ent_we       = 1'b0;
    cnt_next     = cnt_eff;
    st_next      = ST_READ;
    out_ent_next = '0;
    if (cmd_q == CMD_READ) begin
      st_next = ST_READ;
      if (ridx_ok) begin
        out_ent_next = ent_rd;
      end
    end else if (is_dup) begin
      st_next = ST_DUPLICATE;
    end else begin
      hist_we = busy;
      if (wlen_q == 16'd0 && !cfg.include_zero_length) begin
        st_next = ST_ZERO_SKIP;
      end else if (cnt_eff < CNT_MAX) begin
        ent_we   = busy;
        cnt_next = cnt_eff + CW'(1);
        st_next  = ST_RECORDED;
      end else begin
        st_next = ST_FULL;
      end
    end
  end

  // history valid bits: a new flow forgets both directions
  always_comb begin
    hist_valid_next = nf_q ? 2'b00 : hist_valid;
    if (hist_we) begin
      hist_valid_next[dir_q] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      hist_valid <= 2'b00;
      done       <= 1'b0;
    end else begin
      done <= busy;
      if (busy) begin
        cnt        <= cnt_next;
        hist_valid <= hist_valid_next;
      end
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic [CW+5:0] cnt_ext;

  assign cnt_ext = {6'b0, cnt_next};

  always_ff @(posedge clk) begin
    if (busy) begin
      status          <= st_next;
      recorded_count  <= cnt_ext[5:0];
      want_more       <= cnt_next < CNT_MAX;
      entry_size      <= out_ent_next.size;
      entry_flags     <= out_ent_next.flags;
      entry_direction <= out_ent_next.direction;
      entry_time      <= out_ent_next.arrival;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("busy lasted more than one cycle or no result followed");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX)
    else $error("stored count above capacity");

  a_want_more: assert property (@(posedge clk) disable iff (rst)
    done |-> (want_more == (cnt < CNT_MAX)))
    else $error("want_more disagrees with the stored count");

  a_packet_no_entry: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_READ) |->
      (entry_size == 16'd0) && (entry_flags == 8'd0) &&
      (entry_direction == 1'b0) && (entry_time == 64'd0))
    else $error("packet result carries entry data");

endmodule
